// File: rtl/core/cubic_bezier_easing_sampler_defines.svh
// Assertion macros used by the port-level checker of the easing sampler.
// No dependencies.
`ifndef CUBIC_BEZIER_EASING_SAMPLER_DEFINES_SVH
`define CUBIC_BEZIER_EASING_SAMPLER_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define CBES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CBES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cbes_pkg.sv
// Shared constants for the cubic Bezier easing sampler.
// No dependencies.
package cbes_pkg;

   localparam int FRAC_BITS = 16;
   localparam int X_W       = FRAC_BITS + 1;          // progress, 0..ONE
   localparam int T_W       = FRAC_BITS + 2;          // signed t
   localparam int COEF_W    = 24;
   localparam int ACC_W     = 32;                     // Horner accumulator
   localparam int PROD_W    = ACC_W + T_W;
   localparam int NUM_W     = ACC_W + FRAC_BITS;      // Newton dividend
   localparam int DEN_W     = ACC_W;                  // Newton divisor
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [X_W-1:0] ONE_X = X_W'(1) << FRAC_BITS;

   // register indexes on the csr port
   localparam logic [2:0] REG_X_CUBIC  = 3'd0;
   localparam logic [2:0] REG_X_SQUARE = 3'd1;
   localparam logic [2:0] REG_X_LINEAR = 3'd2;
   localparam logic [2:0] REG_Y_CUBIC  = 3'd3;
   localparam logic [2:0] REG_Y_SQUARE = 3'd4;
   localparam logic [2:0] REG_Y_LINEAR = 3'd5;

endpackage

// File: rtl/core/cbes_divider.sv
// Radix-2 restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on cbes_pkg.
module cbes_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               div_start,
   input  logic signed [cbes_pkg::NUM_W-1:0]  div_dividend,
   input  logic signed [cbes_pkg::DEN_W-1:0]  div_divisor,
   output logic                               div_done,
   output logic signed [cbes_pkg::NUM_W-1:0]  div_quotient
);

   localparam int NW = cbes_pkg::NUM_W;
   localparam int DW = cbes_pkg::DEN_W;
   localparam int CW = cbes_pkg::DIV_CNT_W;

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [DW:0]   rem_sh;
   logic          fits;
   logic [DW:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NW-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};

      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (div_start) begin
         num_in  = div_dividend[NW-1] ? NW'(-div_dividend) : NW'(div_dividend);
         den_in  = div_divisor[DW-1] ? DW'(-div_divisor) : DW'(div_divisor);
         neg_in  = div_dividend[NW-1] ^ div_divisor[DW-1];
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// File: rtl/core/cubic_bezier_easing_sampler.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_progress    (Q1.16, 65536 = 1.0)
// rsp      out        rsp_valid/stall    rsp_eased_value (signed Q8.16)
// csr      in         csr_write_enable   csr_index, csr_write_data
// One shared 32x18 multiplier evaluates X, X' and Y by Horner steps, each S_MUL then S_ACC.
// Progress 0 or >= 1.0: result valid in the cycle after transfer. Otherwise an X pass
// checks t, each Newton update runs an X' pass and the bit-serial divider, a flat derivative
// or the last Newton update falls back to bisection steps of one X pass each, then a Y pass.
// req_stall is high from transfer until the result transfer completes.
// Synchronous active-high reset; no memory clearing.
// Depends on cbes_pkg and cbes_divider.
module cubic_bezier_easing_sampler #(
   parameter int NEWTON_ITERATIONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [16:0]                  req_progress,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [23:0]                  rsp_eased_value,
   input  logic                                csr_write_enable,
   input  logic        [2:0]                   csr_index,
   input  logic        [23:0]                  csr_write_data
);

   localparam int XW  = cbes_pkg::X_W;
   localparam int TW  = cbes_pkg::T_W;
   localparam int AW  = cbes_pkg::ACC_W;
   localparam int PW  = cbes_pkg::PROD_W;
   localparam int NW  = cbes_pkg::NUM_W;
   localparam int FB  = cbes_pkg::FRAC_BITS;
   localparam int IW  = $clog2(NEWTON_ITERATIONS + 1);

   localparam logic signed [AW-1:0] OUT_MAX = AW'(8388607);
   localparam logic signed [AW-1:0] OUT_MIN = -AW'(8388608);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_ACC   = 10'b0000000100,
      S_NCHK  = 10'b0000001000,
      S_DCHK  = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_BCOND = 10'b0001000000,
      S_BCHK  = 10'b0010000000,
      S_YSAT  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      M_NX = 2'd0,
      M_D  = 2'd1,
      M_BX = 2'd2,
      M_Y  = 2'd3
   } mode_type;

   logic signed [23:0] ax_ff, bx_ff, cx_ff, ay_ff, by_ff, cy_ff;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic        [1:0]      k_ff, k_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [TW-1:0]   t_ff, t_in;
   logic        [XW-1:0]   x_ff, x_in;
   logic        [XW-1:0]   low_ff, low_in, high_ff, high_in;
   logic signed [AW-1:0]   diff_ff, diff_in;
   logic        [IW-1:0]   iter_ff, iter_in;
   logic signed [23:0]     rsp_eased_value_ff, rsp_eased_value_in;

   logic                   eval_go;
   mode_type               eval_mode;
   logic signed [AW-1:0]   addend;
   logic                   last_step;
   logic signed [PW-1:0]   prod_sh;
   logic signed [AW-1:0]   x_acc, xdiff;
   logic                   near;
   logic        [XW-1:0]   x_sat;
   logic                   div_start, div_done;
   logic signed [NW-1:0]   div_quotient;
   logic signed [NW:0]     t_sub;
   logic        [XW-1:0]   b_low, b_high;

   cbes_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend ({diff_ff, FB'(0)}),
      .div_divisor  (acc_ff),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_comb begin
      x_sat   = req_progress[16] ? cbes_pkg::ONE_X : XW'(req_progress);
      x_acc   = AW'({1'b0, x_ff});
      xdiff   = acc_ff - x_acc;
      near    = (xdiff >= -AW'(1)) && (xdiff <= AW'(1));
      prod_in = acc_ff * t_ff;
      prod_sh = prod_ff >>> FB;
      t_sub   = {{(NW + 1 - TW){t_ff[TW-1]}}, t_ff} - {div_quotient[NW-1], div_quotient};

      unique case (mode_ff)
         M_NX, M_BX: addend = (k_ff == 2'd0) ? AW'(bx_ff) : (k_ff == 2'd1) ? AW'(cx_ff) : '0;
         M_Y:        addend = (k_ff == 2'd0) ? AW'(by_ff) : (k_ff == 2'd1) ? AW'(cy_ff) : '0;
         M_D:        addend = (k_ff == 2'd0) ? (AW'(bx_ff) <<< 1) : AW'(cx_ff);
         default:    addend = '0;
      endcase
      last_step = (mode_ff == M_D) ? (k_ff == 2'd1) : (k_ff == 2'd2);

      if (xdiff < 0) begin
         b_low  = t_ff[XW-1:0];
         b_high = high_ff;
      end else begin
         b_low  = low_ff;
         b_high = t_ff[XW-1:0];
      end
   end

   always_comb begin
      state_in           = state_ff;
      mode_in            = mode_ff;
      k_in               = k_ff;
      acc_in             = acc_ff;
      t_in               = t_ff;
      x_in               = x_ff;
      low_in             = low_ff;
      high_in            = high_ff;
      diff_in            = diff_ff;
      iter_in            = iter_ff;
      rsp_eased_value_in = rsp_eased_value_ff;
      eval_go            = 1'b0;
      eval_mode          = M_NX;
      div_start          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in    = x_sat;
               t_in    = TW'(x_sat);
               iter_in = '0;
               if (x_sat == '0 || x_sat == cbes_pkg::ONE_X) begin
                  rsp_eased_value_in = 24'(x_sat);
                  state_in           = S_OUT;
               end else begin
                  eval_go = 1'b1;
               end
            end
         end
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            acc_in = AW'(prod_sh) + addend;
            k_in   = k_ff + 2'd1;
            if (!last_step) begin
               state_in = S_MUL;
            end else begin
               unique case (mode_ff)
                  M_NX:    state_in = S_NCHK;
                  M_D:     state_in = S_DCHK;
                  M_BX:    state_in = S_BCHK;
                  M_Y:     state_in = S_YSAT;
                  default: state_in = S_YSAT;
               endcase
            end
         end
         S_NCHK: begin
            diff_in = xdiff;
            eval_go = 1'b1;
            eval_mode = near ? M_Y : M_D;
         end
         S_DCHK: begin
            if (acc_ff == '0) begin
               t_in     = TW'(x_ff);
               low_in   = '0;
               high_in  = cbes_pkg::ONE_X;
               state_in = S_BCOND;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               priority if (t_sub[NW]) begin
                  t_in = '0;
               end else if (t_sub > (NW + 1)'(cbes_pkg::ONE_X)) begin
                  t_in = TW'(cbes_pkg::ONE_X);
               end else begin
                  t_in = TW'(t_sub);
               end
               iter_in = iter_ff + IW'(1);
               if (iter_ff == IW'(NEWTON_ITERATIONS - 1)) begin
                  low_in   = '0;
                  high_in  = cbes_pkg::ONE_X;
                  state_in = S_BCOND;
                  t_in     = TW'(x_ff);
               end else begin
                  eval_go = 1'b1;
               end
            end
         end
         S_BCOND: begin
            eval_go   = 1'b1;
            eval_mode = (high_ff - low_ff > XW'(1)) ? M_BX : M_Y;
         end
         S_BCHK: begin
            if (near) begin
               eval_go   = 1'b1;
               eval_mode = M_Y;
            end else begin
               low_in   = b_low;
               high_in  = b_high;
               t_in     = TW'(b_low + ((b_high - b_low) >> 1));
               state_in = S_BCOND;
            end
         end
         S_YSAT: begin
            priority if (acc_ff > OUT_MAX) begin
               rsp_eased_value_in = 24'(OUT_MAX);
            end else if (acc_ff < OUT_MIN) begin
               rsp_eased_value_in = 24'(OUT_MIN);
            end else begin
               rsp_eased_value_in = 24'(acc_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (eval_go) begin
         mode_in  = eval_mode;
         k_in     = '0;
         state_in = S_MUL;
         unique case (eval_mode)
            M_D:     acc_in = AW'(ax_ff) + (AW'(ax_ff) <<< 1);
            M_Y:     acc_in = AW'(ay_ff);
            default: acc_in = AW'(ax_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= M_NX;
         k_ff     <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         k_ff     <= k_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff             <= acc_in;
      prod_ff            <= prod_in;
      t_ff               <= t_in;
      x_ff               <= x_in;
      low_ff             <= low_in;
      high_ff            <= high_in;
      diff_ff            <= diff_in;
      rsp_eased_value_ff <= rsp_eased_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         bx_ff <= '0;
         cx_ff <= 24'sd65536;
         ay_ff <= '0;
         by_ff <= '0;
         cy_ff <= 24'sd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cbes_pkg::REG_X_CUBIC:  ax_ff <= csr_write_data;
            cbes_pkg::REG_X_SQUARE: bx_ff <= csr_write_data;
            cbes_pkg::REG_X_LINEAR: cx_ff <= csr_write_data;
            cbes_pkg::REG_Y_CUBIC:  ay_ff <= csr_write_data;
            cbes_pkg::REG_Y_SQUARE: by_ff <= csr_write_data;
            cbes_pkg::REG_Y_LINEAR: cy_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_eased_value = rsp_eased_value_ff;

endmodule

// File: rtl/core/cbes_checker.sv
// Port-level checks for the cubic Bezier easing sampler, bound to the top level.
// Depends on cubic_bezier_easing_sampler_defines.svh.
`include "cubic_bezier_easing_sampler_defines.svh"

module cbes_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic        [16:0] req_progress,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [23:0] rsp_eased_value
);

   `CBES_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eased_value), "stalled result changed")
   `CBES_ASSERT(a_busy_when_pending, clock, reset, rsp_valid |-> req_stall, "input open while result pending")
   `CBES_ASSERT(a_zero_pass, clock, reset, req_valid && !req_stall && req_progress == 17'd0 |=> rsp_valid && rsp_eased_value == 24'sd0, "progress zero not passed through")
   `CBES_ASSERT(a_one_pass, clock, reset, req_valid && !req_stall && req_progress[16] |=> rsp_valid && rsp_eased_value == 24'sd65536, "progress one not saturated")
   `CBES_ASSERT(a_single_result, clock, reset, rsp_valid && !rsp_stall |=> !rsp_valid, "result repeated")

endmodule

bind cubic_bezier_easing_sampler cbes_checker u_cbes_checker (.*);

// File: verif/cbes_checker.sv
// Checker for the cubic Bezier easing sampler: watches the request and response
// channels and the register port, predicts each eased value and compares.
// Depends on cbes_pkg for the register indexes.
module tb_cbes_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic        [16:0] req_progress,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [23:0] rsp_eased_value,
   input  logic               csr_write_enable,
   input  logic        [2:0]  csr_index,
   input  logic        [23:0] csr_write_data,
   output int                 fail_count,
   output int                 pending
);
   localparam int FB = 16;
   localparam longint ONE = 64'sd1 << FB;
   localparam int NEWTON_STEPS = 8;

   longint xa, xb, xc, ya, yb, yc;
   logic signed [23:0] eased_q[$];

   function automatic longint fx_floor(longint v);
      return v >>> FB;
   endfunction

   function automatic longint horner(longint a, longint b, longint c, longint t);
      longint acc;
      acc = fx_floor(a * t) + b;
      acc = fx_floor(acc * t) + c;
      return fx_floor(acc * t);
   endfunction

   function automatic longint find_t(longint x);
      longint t, lo, hi, diff, d, xs;
      t = x;
      lo = 0;
      hi = ONE;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
         diff = horner(xa, xb, xc, t) - x;
         if (diff <= 1 && diff >= -1) return t;
         d = fx_floor((fx_floor(3 * xa * t) + 2 * xb) * t) + xc;
         if (d == 0) break;
         t = t - (diff * ONE) / d;
         if (t < 0) t = 0;
         if (t > ONE) t = ONE;
      end
      t = x;
      while (hi - lo > 1) begin
         xs = horner(xa, xb, xc, t);
         if (xs - x <= 1 && xs - x >= -1) return t;
         if (x > xs) lo = t;
         else hi = t;
         t = lo + (hi - lo) / 2;
      end
      return t;
   endfunction

   function automatic logic signed [23:0] eased_of(logic [16:0] p);
      longint x, y;
      x = p;
      if (x > ONE) x = ONE;
      if (x == 0 || x == ONE) y = x;
      else y = horner(ya, yb, yc, find_t(x));
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
   endfunction

   assign pending = eased_q.size();

   always @(posedge clock) begin
      logic signed [23:0] want;
      if (reset) begin
         xa <= 0; xb <= 0; xc <= ONE; ya <= 0; yb <= 0; yc <= ONE;
         eased_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               cbes_pkg::REG_X_CUBIC:  xa <= longint'(signed'(csr_write_data));
               cbes_pkg::REG_X_SQUARE: xb <= longint'(signed'(csr_write_data));
               cbes_pkg::REG_X_LINEAR: xc <= longint'(signed'(csr_write_data));
               cbes_pkg::REG_Y_CUBIC:  ya <= longint'(signed'(csr_write_data));
               cbes_pkg::REG_Y_SQUARE: yb <= longint'(signed'(csr_write_data));
               cbes_pkg::REG_Y_LINEAR: yc <= longint'(signed'(csr_write_data));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (eased_q.size() == 0) begin
               $error("eased_value: unexpected transfer, actual %0d", rsp_eased_value);
               fail_count <= fail_count + 1;
            end else begin
               want = eased_q.pop_front();
               if (want !== rsp_eased_value) begin
                  $error("eased_value: expected %0d actual %0d", want, rsp_eased_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) eased_q.push_back(eased_of(req_progress));
      end
   end
endmodule

// File: verif/tb_cubic_bezier_easing_sampler.sv
// Top of the easing sampler testbench: clock, reset, register settings and
// progress stimulus; verdict from the checker. Depends on the block, cbes_pkg, tb_cbes_checker.
module tb_cubic_bezier_easing_sampler;
   localparam logic [2:0] IDX_SPARE = 3'd6;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_write_enable = 0;
   logic [16:0] req_progress = 0;
   logic [2:0] csr_index = 0;
   logic [23:0] csr_write_data = 0;
   logic req_stall, rsp_valid;
   logic signed [23:0] rsp_eased_value;
   int fail_count, pending;
   int send_idle = 0, recv_idle = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   cubic_bezier_easing_sampler uut (.*);
   tb_cbes_checker chk (.*);

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   // Bezier control points (x1,y1,x2,y2) in Q16 to polynomial coefficients
   task automatic set_curve(int x1, int y1, int x2, int y2);
      int cx, bx, cy, by;
      cx = 3 * x1; bx = 3 * (x2 - x1) - cx;
      cy = 3 * y1; by = 3 * (y2 - y1) - cy;
      drain();
      write_reg(cbes_pkg::REG_X_CUBIC, 24'(65536 - cx - bx));
      write_reg(cbes_pkg::REG_X_SQUARE, 24'(bx));
      write_reg(cbes_pkg::REG_X_LINEAR, 24'(cx));
      write_reg(cbes_pkg::REG_Y_CUBIC, 24'(65536 - cy - by));
      write_reg(cbes_pkg::REG_Y_SQUARE, 24'(by));
      write_reg(cbes_pkg::REG_Y_LINEAR, 24'(cy));
   endtask

   task automatic send(logic [16:0] p);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_progress <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic random_items(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(19);
         if (r == 0) send(17'($urandom_range(131071)));
         else if (r == 1) send($urandom_range(1) ? 17'd0 : 17'd65536);
         else if (r == 2) send(17'd65535 - 17'($urandom_range(3)));
         else send(17'($urandom_range(65536)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // identity curve, then directed extremes
      send(17'd0); send(17'd1); send(17'd65535); send(17'd65536); send(17'd65537);
      send(17'h1FFFF); send(17'd32768); send(17'h15555); send(17'h0AAAA);
      set_curve(16384, 6554, 16384, 65536);     // ease
      send(17'd1); send(17'd16384); send(17'd49152); send(17'd65535);
      set_curve(45875, -35000, 19661, 100000);  // overshoot both ways
      send(17'd20000); send(17'd45000);
      drain();                                   // flat derivative, x constant zero
      write_reg(cbes_pkg::REG_X_CUBIC, 24'd0); write_reg(cbes_pkg::REG_X_SQUARE, 24'd0);
      write_reg(cbes_pkg::REG_X_LINEAR, 24'd0);
      write_reg(IDX_SPARE, 24'hFFFFFF);
      send(17'd30000); send(17'd1);
      drain();                                   // register extremes, saturating output
      write_reg(cbes_pkg::REG_X_CUBIC, 24'h7FFFFF); write_reg(cbes_pkg::REG_X_SQUARE, 24'h800000);
      write_reg(cbes_pkg::REG_X_LINEAR, 24'h7FFFFF); write_reg(cbes_pkg::REG_Y_CUBIC, 24'h7FFFFF);
      write_reg(cbes_pkg::REG_Y_SQUARE, 24'h7FFFFF); write_reg(cbes_pkg::REG_Y_LINEAR, 24'h7FFFFF);
      send(17'd40000); send(17'd100);
      drain();
      write_reg(cbes_pkg::REG_Y_CUBIC, 24'h800000); write_reg(cbes_pkg::REG_Y_SQUARE, 24'h800000);
      write_reg(cbes_pkg::REG_Y_LINEAR, 24'h800000);
      send(17'd40000); send(17'd65535);
      send_idle = 29; recv_idle = 71;
      set_curve(27525, 0, 38010, 65536);
      random_items(300);
      send_idle = 71; recv_idle = 29;
      set_curve($urandom_range(65536), $urandom_range(200000) - 70000,
                $urandom_range(65536), $urandom_range(200000) - 70000);
      random_items(300);
      drain();                                   // random raw coefficients
      write_reg(cbes_pkg::REG_X_CUBIC, 24'($urandom));
      write_reg(cbes_pkg::REG_X_SQUARE, 24'($urandom));
      write_reg(cbes_pkg::REG_X_LINEAR, 24'($urandom));
      write_reg(cbes_pkg::REG_Y_CUBIC, 24'($urandom));
      write_reg(cbes_pkg::REG_Y_SQUARE, 24'($urandom));
      write_reg(cbes_pkg::REG_Y_LINEAR, 24'($urandom));
      random_items(100);
      send_idle = 0; recv_idle = 0;
      for (int c = 0; c < 6; c++) begin
         set_curve($urandom_range(65536), $urandom_range(200000) - 70000,
                   $urandom_range(65536), $urandom_range(200000) - 70000);
         random_items(100);
      end
      drain();
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #(64'd60000000);
      $display("status: fail");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cbes_pkg.sv
rtl/core/cbes_divider.sv
rtl/core/cubic_bezier_easing_sampler.sv
rtl/core/cbes_checker.sv
verif/cbes_checker.sv
verif/tb_cubic_bezier_easing_sampler.sv
